// ----- src/ppdr_pkg.sv -----
// Shared constants and register codes for the point pair distance relaxation block.
package ppdr_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int STEP_W         = 17;
   localparam int STEP_FRAC      = 16;
   localparam int TOL_W          = 16;
   localparam int CSR_IDX_W      = 8;
   localparam int CSR_DATA_W     = 32;

   localparam logic [STEP_W-1:0] STEP_RESET = 17'd65536;
   localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE = 8'd0,
      CSR_TOLERANCE = 8'd1
   } csr_index_type;

endpackage

// ----- src/ppdr_sqrt_cell.sv -----
// One digit of the pipelined integer square root: two radicand bits in, one root bit out.
module ppdr_sqrt_cell #(
   parameter int DB = 33,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*DB-1:0] rad_i,
   input  logic [DB+1:0]   rem_i,
   input  logic [DB-1:0]   root_i,
   input  logic [SW-1:0]   side_i,
   output logic [2*DB-1:0] rad_ff,
   output logic [DB+1:0]   rem_ff,
   output logic [DB-1:0]   root_ff,
   output logic [SW-1:0]   side_ff
);

   logic [DB+3:0]   t;
   logic [DB+3:0]   trial;
   logic [DB+3:0]   diff;
   logic            ge;
   logic [2*DB-1:0] rad_in;
   logic [DB+1:0]   rem_in;
   logic [DB-1:0]   root_in;

   always_comb begin
      t       = {rem_i, rad_i[2*DB-1 -: 2]};
      trial   = {2'b00, root_i, 2'b01};
      diff    = t - trial;
      ge      = (t >= trial);
      rem_in  = ge ? diff[DB+1:0] : t[DB+1:0];
      root_in = {root_i[DB-2:0], ge};
      rad_in  = {rad_i[2*DB-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_i;
      end
   end

endmodule

// ----- src/ppdr_div_cell.sv -----
// One quotient bit of the two-lane restoring divider that shares a single divisor.
module ppdr_div_cell #(
   parameter int DB = 33,
   parameter int QB = 33,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DB-1:0] dsr_i,
   input  logic [DB-1:0] rx_i,
   input  logic [DB-1:0] ry_i,
   input  logic [QB-1:0] nx_i,
   input  logic [QB-1:0] ny_i,
   input  logic [QB-1:0] qx_i,
   input  logic [QB-1:0] qy_i,
   input  logic [SW-1:0] side_i,
   output logic [DB-1:0] dsr_ff,
   output logic [DB-1:0] rx_ff,
   output logic [DB-1:0] ry_ff,
   output logic [QB-1:0] nx_ff,
   output logic [QB-1:0] ny_ff,
   output logic [QB-1:0] qx_ff,
   output logic [QB-1:0] qy_ff,
   output logic [SW-1:0] side_ff
);

   logic [DB:0]   tx, ty, dx, dy, dsr_e;
   logic          gex, gey;
   logic [DB-1:0] rx_in, ry_in;

   always_comb begin
      dsr_e = {1'b0, dsr_i};
      tx    = {rx_i, nx_i[QB-1]};
      ty    = {ry_i, ny_i[QB-1]};
      dx    = tx - dsr_e;
      dy    = ty - dsr_e;
      gex   = (tx >= dsr_e);
      gey   = (ty >= dsr_e);
      rx_in = gex ? dx[DB-1:0] : tx[DB-1:0];
      ry_in = gey ? dy[DB-1:0] : ty[DB-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dsr_ff  <= dsr_i;
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         nx_ff   <= {nx_i[QB-2:0], 1'b0};
         ny_ff   <= {ny_i[QB-2:0], 1'b0};
         qx_ff   <= {qx_i[QB-2:0], gex};
         qy_ff   <= {qy_i[QB-2:0], gey};
         side_ff <= side_i;
      end
   end

endmodule

// ----- src/point_pair_distance_relaxation.sv -----
// Top level of the point pair distance relaxation pipeline.
//
//   channel  direction  handshake              contents
//   req_     in         req_valid/req_ready    two points and a target distance
//   rsp_     out        rsp_valid/rsp_ready    moved points, error and flags
//   csr_     in         csr_valid/csr_ready    register index and write data
//
// One item is taken every cycle while req_ready is high; the square root chain
// (one root bit per cell) and the divider chain (one quotient bit per cell) run
// in series.
// Reset clears all valid flags and loads the step size and tolerance defaults.
// A stalled result waits in the output register; one further item is caught in a
// skid register, after which the whole chain holds and req_ready falls.
module point_pair_distance_relaxation #(
   parameter int COORD_BITS = ppdr_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_BITS-1:0]        req_first_x,
   input  logic signed [COORD_BITS-1:0]        req_first_y,
   input  logic signed [COORD_BITS-1:0]        req_second_x,
   input  logic signed [COORD_BITS-1:0]        req_second_y,
   input  logic [COORD_BITS-2:0]               req_target_distance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [COORD_BITS-1:0]        rsp_new_first_x,
   output logic signed [COORD_BITS-1:0]        rsp_new_first_y,
   output logic signed [COORD_BITS-1:0]        rsp_new_second_x,
   output logic signed [COORD_BITS-1:0]        rsp_new_second_y,
   output logic [COORD_BITS-1:0]               rsp_distance_error,
   output logic                                rsp_satisfied,
   output logic                                rsp_degenerate,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppdr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppdr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ppdr_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int AW  = CB + 1;
   localparam int DB  = AW;
   localparam int RB  = 2 * DB;
   localparam int PW  = 2 * AW;
   localparam int NFW = PW + STEP_W + 1;
   localparam int NW  = NFW - STEP_FRAC - 1;
   localparam int QB  = AW;
   localparam int EW  = CB + 3;
   localparam int SW1 = 5 * CB - 1 + 2 + 2 * AW;
   localparam int SW2 = 6 * CB + 6;
   localparam int ROW = 5 * CB + 2;
   localparam int NV  = 6 + DB + QB;

   localparam logic signed [EW-1:0] MAXV = {4'b0000, {(CB-1){1'b1}}};
   localparam logic signed [EW-1:0] MINV = {4'b1111, {(CB-1){1'b0}}};

   function automatic logic [CB-1:0] clamp_c(input logic signed [EW-1:0] v);
      logic [CB-1:0] r;
      if (v > MAXV) begin
         r = MAXV[CB-1:0];
      end else if (v < MINV) begin
         r = MINV[CB-1:0];
      end else begin
         r = v[CB-1:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic [STEP_W-1:0] step_ff;
   logic [TOL_W-1:0]  tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         tol_ff  <= TOL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_SIZE: step_ff <= csr_data[STEP_W-1:0];
            CSR_TOLERANCE: tol_ff  <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: the chain advances as one while the skid register is empty.
   logic          adv;
   logic [NV-1:0] v_ff;
   logic          out_v_ff, skid_v_ff;

   assign adv       = !skid_v_ff;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NV-2:0], req_valid};
      end
   end

   // Stage 0: input registers.
   logic [CB-1:0] s0_x1_ff, s0_y1_ff, s0_x2_ff, s0_y2_ff;
   logic [CB-2:0] s0_tgt_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_x1_ff  <= req_first_x;
         s0_y1_ff  <= req_first_y;
         s0_x2_ff  <= req_second_x;
         s0_y2_ff  <= req_second_y;
         s0_tgt_ff <= req_target_distance;
      end
   end

   // Stage 1: differences, magnitudes and squares.
   logic [AW-1:0]  dxs, dys, adx, ady;
   logic [PW-1:0]  s1_sqx_ff, s1_sqy_ff;
   logic [SW1-1:0] s1_side_ff;

   always_comb begin
      dxs = {s0_x2_ff[CB-1], s0_x2_ff} - {s0_x1_ff[CB-1], s0_x1_ff};
      dys = {s0_y2_ff[CB-1], s0_y2_ff} - {s0_y1_ff[CB-1], s0_y1_ff};
      adx = dxs[AW-1] ? (~dxs + 1'b1) : dxs;
      ady = dys[AW-1] ? (~dys + 1'b1) : dys;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sqx_ff  <= adx * adx;
         s1_sqy_ff  <= ady * ady;
         s1_side_ff <= {s0_x1_ff, s0_y1_ff, s0_x2_ff, s0_y2_ff, s0_tgt_ff,
                        dxs[AW-1], dys[AW-1], adx, ady};
      end
   end

   // Stage 2: sum of squares, which always fits the radicand width.
   logic [PW:0]    sum_full;
   logic [RB-1:0]  s2_sum_ff;
   logic [SW1-1:0] s2_side_ff;

   assign sum_full = {1'b0, s1_sqx_ff} + {1'b0, s1_sqy_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sum_ff  <= sum_full[RB-1:0];
         s2_side_ff <= s1_side_ff;
      end
   end

   // Square root chain.
   logic [RB-1:0]  rad_w  [DB+1];
   logic [DB+1:0]  rem_w  [DB+1];
   logic [DB-1:0]  root_w [DB+1];
   logic [SW1-1:0] sq_side_w [DB+1];

   assign rad_w[0]     = s2_sum_ff;
   assign rem_w[0]     = '0;
   assign root_w[0]    = '0;
   assign sq_side_w[0] = s2_side_ff;

   for (genvar k = 0; k < DB; k++) begin : g_sqrt
      ppdr_sqrt_cell #(.DB(DB), .SW(SW1)) u_cell (
         .clock   (clock),
         .en      (adv),
         .rad_i   (rad_w[k]),
         .rem_i   (rem_w[k]),
         .root_i  (root_w[k]),
         .side_i  (sq_side_w[k]),
         .rad_ff  (rad_w[k+1]),
         .rem_ff  (rem_w[k+1]),
         .root_ff (root_w[k+1]),
         .side_ff (sq_side_w[k+1])
      );
   end

   // Stage P1: error, flags and the first products.
   logic [CB-1:0] q_x1, q_y1, q_x2, q_y2;
   logic [CB-2:0] q_tgt;
   logic          q_sx, q_sy;
   logic [AW-1:0] q_adx, q_ady, root_dist, tgt_e, err;
   logic          grow;

   assign {q_x1, q_y1, q_x2, q_y2, q_tgt, q_sx, q_sy, q_adx, q_ady} = sq_side_w[DB];
   assign root_dist = root_w[DB];

   always_comb begin
      tgt_e = {2'b00, q_tgt};
      grow  = (tgt_e >= root_dist);
      err   = grow ? (tgt_e - root_dist) : (root_dist - tgt_e);
   end

   logic [CB-1:0]     p1_x1_ff, p1_y1_ff, p1_x2_ff, p1_y2_ff, p1_err_ff;
   logic              p1_sat_ff, p1_degen_ff, p1_negx_ff, p1_negy_ff;
   logic [PW-1:0]     p1_px_ff, p1_py_ff;
   logic [CB+15:0]    p1_ps_ff;
   logic [AW-1:0]     p1_dist_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_x1_ff    <= q_x1;
         p1_y1_ff    <= q_y1;
         p1_x2_ff    <= q_x2;
         p1_y2_ff    <= q_y2;
         p1_err_ff   <= err[AW-1] ? {CB{1'b1}} : err[CB-1:0];
         p1_sat_ff   <= (err <= {{(AW-TOL_W){1'b0}}, tol_ff});
         p1_degen_ff <= (root_dist <= {{(AW-TOL_W){1'b0}}, tol_ff});
         p1_negx_ff  <= q_sx ^ ~grow;
         p1_negy_ff  <= q_sy ^ ~grow;
         p1_px_ff    <= q_adx * err;
         p1_py_ff    <= q_ady * err;
         p1_ps_ff    <= q_tgt * step_ff;
         p1_dist_ff  <= root_dist;
      end
   end

   // Stage P2: numerators scaled by the step with the rounding half added, and the
   // x shift of the degenerate case.
   logic [PW+STEP_W-1:0] prod_x, prod_y;
   logic [NFW-1:0] half_e, nfx, nfy;
   logic [CB+16:0] ps_r;
   logic [CB:0]    shift;
   logic [EW-1:0]  nsx_full;

   always_comb begin
      prod_x   = p1_px_ff * step_ff;
      prod_y   = p1_py_ff * step_ff;
      half_e   = {{(NFW-DB-STEP_FRAC){1'b0}}, p1_dist_ff, {STEP_FRAC{1'b0}}};
      nfx      = {1'b0, prod_x} + half_e;
      nfy      = {1'b0, prod_y} + half_e;
      ps_r     = {1'b0, p1_ps_ff} + {{(CB+1){1'b0}}, 1'b1, {(STEP_FRAC-1){1'b0}}};
      shift    = ps_r[CB+16:STEP_FRAC];
      nsx_full = {{3{p1_x2_ff[CB-1]}}, p1_x2_ff} + {2'b00, shift};
   end

   logic [NW-1:0] p2_nx_ff, p2_ny_ff;
   logic [CB-1:0] p2_x1_ff, p2_y1_ff, p2_x2_ff, p2_y2_ff, p2_err_ff, p2_nsx_ff;
   logic          p2_sat_ff, p2_degen_ff, p2_negx_ff, p2_negy_ff;
   logic [AW-1:0] p2_dist_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_nx_ff    <= nfx[NFW-1:STEP_FRAC+1];
         p2_ny_ff    <= nfy[NFW-1:STEP_FRAC+1];
         p2_x1_ff    <= p1_x1_ff;
         p2_y1_ff    <= p1_y1_ff;
         p2_x2_ff    <= p1_x2_ff;
         p2_y2_ff    <= p1_y2_ff;
         p2_err_ff   <= p1_err_ff;
         p2_nsx_ff   <= clamp_c(nsx_full);
         p2_sat_ff   <= p1_sat_ff;
         p2_degen_ff <= p1_degen_ff;
         p2_negx_ff  <= p1_negx_ff;
         p2_negy_ff  <= p1_negy_ff;
         p2_dist_ff  <= p1_dist_ff;
      end
   end

   // Stage P3: a quotient that needs more bits than the chain makes saturates; the
   // high part of each numerator is then already the first partial remainder.
   logic [NW-QB-1:0] hix, hiy;
   logic             ovx, ovy;

   always_comb begin
      hix = p2_nx_ff[NW-1:QB];
      hiy = p2_ny_ff[NW-1:QB];
      ovx = (hix >= {1'b0, p2_dist_ff});
      ovy = (hiy >= {1'b0, p2_dist_ff});
   end

   logic [DB-1:0]  dsr_w [QB+1];
   logic [DB-1:0]  rx_w  [QB+1];
   logic [DB-1:0]  ry_w  [QB+1];
   logic [QB-1:0]  nx_w  [QB+1];
   logic [QB-1:0]  ny_w  [QB+1];
   logic [QB-1:0]  qx_w  [QB+1];
   logic [QB-1:0]  qy_w  [QB+1];
   logic [SW2-1:0] dv_side_w [QB+1];

   logic [DB-1:0]  p3_dsr_ff, p3_rx_ff, p3_ry_ff;
   logic [QB-1:0]  p3_nx_ff, p3_ny_ff;
   logic [SW2-1:0] p3_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_dsr_ff  <= p2_dist_ff;
         p3_rx_ff   <= hix[DB-1:0];
         p3_ry_ff   <= hiy[DB-1:0];
         p3_nx_ff   <= p2_nx_ff[QB-1:0];
         p3_ny_ff   <= p2_ny_ff[QB-1:0];
         p3_side_ff <= {p2_x1_ff, p2_y1_ff, p2_x2_ff, p2_y2_ff, p2_err_ff,
                        p2_sat_ff, p2_degen_ff, p2_nsx_ff, p2_negx_ff, p2_negy_ff,
                        ovx, ovy};
      end
   end

   assign dsr_w[0]     = p3_dsr_ff;
   assign rx_w[0]      = p3_rx_ff;
   assign ry_w[0]      = p3_ry_ff;
   assign nx_w[0]      = p3_nx_ff;
   assign ny_w[0]      = p3_ny_ff;
   assign qx_w[0]      = '0;
   assign qy_w[0]      = '0;
   assign dv_side_w[0] = p3_side_ff;

   for (genvar k = 0; k < QB; k++) begin : g_div
      ppdr_div_cell #(.DB(DB), .QB(QB), .SW(SW2)) u_cell (
         .clock   (clock),
         .en      (adv),
         .dsr_i   (dsr_w[k]),
         .rx_i    (rx_w[k]),
         .ry_i    (ry_w[k]),
         .nx_i    (nx_w[k]),
         .ny_i    (ny_w[k]),
         .qx_i    (qx_w[k]),
         .qy_i    (qy_w[k]),
         .side_i  (dv_side_w[k]),
         .dsr_ff  (dsr_w[k+1]),
         .rx_ff   (rx_w[k+1]),
         .ry_ff   (ry_w[k+1]),
         .nx_ff   (nx_w[k+1]),
         .ny_ff   (ny_w[k+1]),
         .qx_ff   (qx_w[k+1]),
         .qy_ff   (qy_w[k+1]),
         .side_ff (dv_side_w[k+1])
      );
   end

   // Final moves, clamping and the degenerate selection.
   logic [CB-1:0] f_x1, f_y1, f_x2, f_y2, f_err, f_nsx;
   logic          f_sat, f_degen, f_negx, f_negy, f_ovx, f_ovy;
   logic [EW-1:0] mx, my, smx, smy, x1e, y1e, x2e, y2e;
   logic [CB-1:0] n1x, n1y, n2x, n2y;
   logic [ROW-1:0] fin;

   assign {f_x1, f_y1, f_x2, f_y2, f_err, f_sat, f_degen, f_nsx, f_negx, f_negy,
           f_ovx, f_ovy} = dv_side_w[QB];

   always_comb begin
      mx  = f_ovx ? {3'b001, {CB{1'b0}}} : {2'b00, qx_w[QB]};
      my  = f_ovy ? {3'b001, {CB{1'b0}}} : {2'b00, qy_w[QB]};
      smx = f_negx ? (~mx + 1'b1) : mx;
      smy = f_negy ? (~my + 1'b1) : my;
      x1e = {{3{f_x1[CB-1]}}, f_x1};
      y1e = {{3{f_y1[CB-1]}}, f_y1};
      x2e = {{3{f_x2[CB-1]}}, f_x2};
      y2e = {{3{f_y2[CB-1]}}, f_y2};
      if (f_degen) begin
         n1x = f_x1;
         n1y = f_y1;
         n2x = f_nsx;
         n2y = f_y2;
      end else begin
         n1x = clamp_c(x1e - smx);
         n1y = clamp_c(y1e - smy);
         n2x = clamp_c(x2e + smx);
         n2y = clamp_c(y2e + smy);
      end
      fin = {n1x, n1y, n2x, n2y, f_err, f_sat, f_degen};
   end

   // Output register with a skid register behind it.
   logic [ROW-1:0] out_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_ready || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= v_ff[NV-1];
         end
      end else if (adv && v_ff[NV-1]) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !out_v_ff) begin
         out_ff <= skid_v_ff ? skid_ff : fin;
      end else if (adv && v_ff[NV-1]) begin
         skid_ff <= fin;
      end
   end

   assign rsp_valid = out_v_ff;
   assign {rsp_new_first_x, rsp_new_first_y, rsp_new_second_x, rsp_new_second_y,
           rsp_distance_error, rsp_satisfied, rsp_degenerate} = out_ff;

   // The input side only stalls once a result waits and the skid register is full.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && skid_v_ff))
      else $error("input stalled without a waiting result");

   // A held result must not be dropped before it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result lost while stalled");

   // The satisfied flag agrees with the reported error.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_satisfied) |->
         (rsp_distance_error <= {{(CB-TOL_W){1'b0}}, tol_ff}))
      else $error("satisfied flag disagrees with error");

   // Nothing is valid right after reset.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && v_ff == '0))
      else $error("valid state after reset");

endmodule

// ----- test/tb_point_pair_distance_relaxation.sv -----
// Testbench for the point pair distance relaxation block, checked against a predictor.
module tb_point_pair_distance_relaxation;
   import ppdr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 32;
   localparam int LATENCY = 2 * CW + 9;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic signed [CW-1:0] first_x, first_y, second_x, second_y;
      logic [CW-1:0]        error;
      logic                 satisfied, degenerate;
   } move_result_type;

   // Predicts the corrected points and queues them until the block returns them.
   class relaxation_board_type;
      logic [STEP_W-1:0] step_gain = STEP_RESET;
      logic [TOL_W-1:0]  tolerance = TOL_RESET;
      move_result_type pending[$];
      int errors = 0;

      function logic signed [CW-1:0] clamp_coord(logic signed [71:0] v);
         if (v > 72'sd2147483647) return 32'sh7FFF_FFFF;
         if (v < -72'sd2147483648) return 32'sh8000_0000;
         return v[CW-1:0];
      endfunction

      function logic [63:0] root_of(logic [127:0] v);
         logic [63:0]  r;
         logic [63:0]  c;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= v) r = c;
         end
         return r;
      endfunction

      function void note_item(longint x1, longint y1, longint x2, longint y2, longint tgt);
         move_result_type m;
         longint dx, dy, mx, my, root_dist, adiff;
         logic [127:0] adx, ady, den, nx, ny, qx, qy;
         logic grow;
         dx = x2 - x1;
         dy = y2 - y1;
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         root_dist = longint'(root_of(adx * adx + ady * ady));
         adiff = root_dist > tgt ? root_dist - tgt : tgt - root_dist;
         m.error = adiff > 64'sd4294967295 ? 32'hFFFF_FFFF : adiff[31:0];
         m.satisfied = adiff <= longint'(tolerance);
         m.degenerate = root_dist <= longint'(tolerance);
         m.first_x = x1[CW-1:0]; m.first_y = y1[CW-1:0];
         m.second_x = x2[CW-1:0]; m.second_y = y2[CW-1:0];
         if (m.degenerate) begin
            m.second_x = clamp_coord(72'(x2) +
                                     72'((tgt * longint'(step_gain) + 32768) >>> 16));
         end else begin
            grow = tgt >= root_dist;
            den = 128'(root_dist) << 17;
            nx = adx * 128'(adiff) * 128'(step_gain) + (den >> 1);
            ny = ady * 128'(adiff) * 128'(step_gain) + (den >> 1);
            qx = nx / den;
            qy = ny / den;
            if (qx > (128'd1 << 62)) qx = 128'd1 << 62;
            if (qy > (128'd1 << 62)) qy = 128'd1 << 62;
            mx = longint'(qx);
            my = longint'(qy);
            if ((dx < 0) != !grow) mx = -mx;
            if ((dy < 0) != !grow) my = -my;
            m.first_x = clamp_coord(72'(x1) - 72'(mx));
            m.first_y = clamp_coord(72'(y1) - 72'(my));
            m.second_x = clamp_coord(72'(x2) + 72'(mx));
            m.second_y = clamp_coord(72'(y2) + 72'(my));
         end
         pending.push_back(m);
      endfunction

      function void check_result(move_result_type got);
         move_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result fx=%h", $realtime, got.first_x);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected fx=%h fy=%h sx=%h sy=%h err=%h sat=%b deg=%b",
                     $realtime, want.first_x, want.first_y, want.second_x, want.second_y,
                     want.error, want.satisfied, want.degenerate);
            $display("%0t:          actual   fx=%h fy=%h sx=%h sy=%h err=%h sat=%b deg=%b",
                     $realtime, got.first_x, got.first_y, got.second_x, got.second_y,
                     got.error, got.satisfied, got.degenerate);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic signed [CW-1:0] req_first_x = 0, req_first_y = 0, req_second_x = 0, req_second_y = 0;
   logic [CW-2:0] req_target_distance = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [CW-1:0] rsp_new_first_x, rsp_new_first_y, rsp_new_second_x, rsp_new_second_y;
   logic [CW-1:0] rsp_distance_error;
   logic rsp_satisfied, rsp_degenerate;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_STEP_SIZE;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   relaxation_board_type board = new();
   longint cycle_count = 0;
   int hold_off = 0;

   point_pair_distance_relaxation u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         board.check_result('{rsp_new_first_x, rsp_new_first_y, rsp_new_second_x,
                              rsp_new_second_y, rsp_distance_error, rsp_satisfied,
                              rsp_degenerate});

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   // Receiver: random stalls, with a long hold-off on request.
   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         g = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
         if (g > 0) begin
            rsp_ready <= 0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1;
      end
   end

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_STEP_SIZE) board.step_gain = value[STEP_W-1:0];
      else board.tolerance = value[TOL_W-1:0];
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_item(logic [31:0] x1, y1, x2, y2, logic [30:0] tgt, bit idle = 1);
      int g;
      @(negedge clock);
      if (idle) begin
         g = ($urandom_range(0, 2) == 0) ? gap_length() : 0;
         if (g > 0) begin
            req_valid <= 0;
            repeat (g) @(negedge clock);
         end
      end
      req_valid <= 1;
      req_first_x <= x1; req_first_y <= y1; req_second_x <= x2; req_second_y <= y2;
      req_target_distance <= tgt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_item(longint'($signed(x1)), longint'($signed(y1)), longint'($signed(x2)),
                      longint'($signed(y2)), longint'(tgt));
      // Valid stays high after the item is taken; the next call may lower it for a gap,
      // or else the caller lowers it at a falling edge.
   endtask

   function automatic logic [31:0] random_coord(int shape);
      unique case (shape)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
         default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
      endcase
   endfunction

   task automatic random_item(bit idle);
      int shape;
      logic [31:0] x1, y1;
      shape = $urandom_range(0, 4);
      x1 = random_coord(shape);
      y1 = random_coord(shape);
      if ($urandom_range(0, 15) == 0)
         send_item(x1, y1, x1 + $urandom_range(0, 1), y1, 31'($urandom()), idle);
      else
         send_item(x1, y1, random_coord(shape), random_coord(shape),
                   shape == 0 ? 31'($urandom()) : 31'($urandom_range(0, 300 << 16)), idle);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 0;
      drain();
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   initial begin
      logic [31:0] maxc, minc;
      maxc = 32'h7FFF_FFFF;
      minc = 32'h8000_0000;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: coincident points, extremes, growing and shrinking, exact match.
      send_item(0, 0, 0, 0, 31'h10000);
      send_item(0, 0, 0, 0, 31'h7FFF_FFFF);
      send_item(maxc, 0, maxc, 0, 31'h7FFF_FFFF);
      send_item(minc, minc, maxc, maxc, 31'd0);
      send_item(maxc, maxc, minc, minc, 31'h7FFF_FFFF);
      send_item(minc, maxc, maxc, minc, 31'h1_0000);
      send_item(0, 0, 32'h3_0000, 32'h4_0000, 31'h5_0000);
      send_item(0, 0, 32'h3_0000, 32'h4_0000, 31'hA_0000);
      send_item(0, 0, 32'h3_0000, 32'h4_0000, 31'd0);
      send_item(32'hFFFF_0000, 5, 32'h0001_0000, 5, 31'h4_0000);
      send_item(0, 0, 1, 0, 31'h100);
      send_item(0, 0, 2, 0, 31'h100);
      send_item(7, 7, 7, 9, 31'd2);
      send_item(maxc, maxc, maxc, maxc, 31'h7FFF_FFFF);
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         unique case (phase)
            0: begin
               write_register(CSR_STEP_SIZE, 32'd0);
               write_register(CSR_TOLERANCE, 32'd0);
            end
            1: begin
               write_register(CSR_STEP_SIZE, 32'd131071);
               write_register(CSR_TOLERANCE, 32'h0000_FFFF);
            end
            2: begin
               write_register(CSR_STEP_SIZE, 32'd65536);
               write_register(CSR_TOLERANCE, 32'h0000_0001);
            end
            3: begin
               write_register(CSR_STEP_SIZE, 32'd32768);
               write_register(CSR_TOLERANCE, 32'h0000_0100);
            end
            4: write_register(CSR_STEP_SIZE, $urandom_range(0, 65536));
            default: write_register(CSR_TOLERANCE, $urandom_range(0, 65535));
         endcase
         for (int i = 0; i < 250; i++) begin
            if (i == 100) hold_off = 300;
            // Stretches without idling keep valid high back to back.
            random_item(!(i >= 100 && i < 200));
         end
         @(negedge clock);
         req_valid <= 0;
         settle();
      end
      settle();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ----- filelist.f -----
src/ppdr_pkg.sv
src/ppdr_sqrt_cell.sv
src/ppdr_div_cell.sv
src/point_pair_distance_relaxation.sv
test/tb_point_pair_distance_relaxation.sv
